/* design/oit_pkg.sv */
// Shared types and constants for the offside indent tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package oit_pkg;

  localparam int COUNT_BITS      = 8;
  localparam int KIND_BITS       = 3;
  localparam int LEVEL_OUT_BITS  = 8;
  localparam int IN_DATA_BITS    = 16;
  localparam int IN_USER_BITS    = 2;
  localparam int DEF_STACK_DEPTH = 32;
  localparam int DEF_LEVEL_BITS  = 8;
  localparam int QUEUE_DEPTH     = 4;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_INDENT       = 3'd0,
    KIND_DEDENT       = 3'd1,
    KIND_MIXED        = 3'd2,
    KIND_INCONSISTENT = 3'd3,
    KIND_MALFORMED    = 3'd4,
    KIND_OVERFLOW     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    SP_NONE   = 2'd0,
    SP_SPACES = 2'd1,
    SP_TABS   = 2'd2
  } spacing_t;

  typedef enum logic [1:0] {
    CMD_LINE   = 2'd0,
    CMD_EOI    = 2'd1,
    CMD_MIXED  = 2'd2,
    CMD_INCONS = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic colon;
    logic malformed;
  } line_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_MALF,
    S_PUSH,
    S_WAIT,
    S_SCAN,
    S_FIN
  } back_state_t;

endpackage

`default_nettype wire

/* design/oit_front.sv */
// Front end: accepts line descriptors, checks spacing, tracks the previous level.
// Depends on oit_pkg; feeds oit_fifo.
`default_nettype none

module oit_front
  import oit_pkg::*;
#(
  parameter int LEVEL_BITS = DEF_LEVEL_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COUNT_BITS-1:0] space_count,
  input  wire logic [COUNT_BITS-1:0] tab_count,
  input  wire logic                  after_colon,
  input  wire logic                  in_group,
  input  wire logic                  end_of_input,
  input  wire logic                  q_full,
  output logic                       q_push,
  output line_ctl_t                  q_ctl,
  output logic [LEVEL_BITS-1:0]      q_cur,
  output logic [LEVEL_BITS-1:0]      q_prev
);

  spacing_t              spacing_kind;
  spacing_t              spacing_kind_next;
  logic [LEVEL_BITS-1:0] previous_level;
  logic [COUNT_BITS-1:0] raw;
  logic [LEVEL_BITS-1:0] cur;
  logic                  accept;
  logic                  mixed;
  logic                  incons;
  logic                  update;

  assign raw = space_count | tab_count;

  generate
    if (LEVEL_BITS >= COUNT_BITS) begin : g_wide
      assign cur = LEVEL_BITS'(raw);
    end else begin : g_sat
      assign cur = ((raw >> LEVEL_BITS) != '0) ? '1 : raw[LEVEL_BITS-1:0];
    end
  endgenerate

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign mixed    = (space_count != '0) && (tab_count != '0);
  assign incons   = ((space_count != '0) && (spacing_kind == SP_TABS)) ||
                    ((tab_count != '0) && (spacing_kind == SP_SPACES));
  assign q_push   = accept && (end_of_input || !in_group);
  assign update   = accept && !end_of_input && !in_group && !mixed && !incons;

  always_comb begin
    q_ctl.colon     = after_colon;
    q_ctl.malformed = (cur <= previous_level);
    priority if (end_of_input) begin
      q_ctl.cmd = CMD_EOI;
    end else if (mixed) begin
      q_ctl.cmd = CMD_MIXED;
    end else if (incons) begin
      q_ctl.cmd = CMD_INCONS;
    end else begin
      q_ctl.cmd = CMD_LINE;
    end
    q_cur  = cur;
    q_prev = previous_level;
  end

  always_comb begin
    priority if (raw == '0) begin
      spacing_kind_next = SP_NONE;
    end else if (space_count != '0) begin
      spacing_kind_next = SP_SPACES;
    end else begin
      spacing_kind_next = SP_TABS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_kind   <= SP_NONE;
      previous_level <= '0;
    end else if (update) begin
      spacing_kind   <= spacing_kind_next;
      previous_level <= cur;
    end
  end

endmodule

`default_nettype wire

/* design/oit_fifo.sv */
// Small register queue between the front end and the stack engine.
// Depends on oit_pkg for the default depth, QUEUE_DEPTH.
`default_nettype none

module oit_fifo
  import oit_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int FILL_W = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [WIDTH-1:0]  wr_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [WIDTH-1:0]       rd_data,
  output logic                   empty,
  output logic [FILL_W-1:0]      fill
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == FILL_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/oit_back.sv */
// Stack engine: level stack in memory, indent/dedent sequencing, result register.
// Depends on oit_pkg; reads from oit_fifo.
`default_nettype none

module oit_back
  import oit_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int LEVEL_BITS  = DEF_LEVEL_BITS,
  localparam int CNT_W = $clog2(STACK_DEPTH + 1),
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      q_empty,
  output logic                           q_pop,
  input  wire line_ctl_t                 q_ctl,
  input  wire logic [LEVEL_BITS-1:0]     q_cur,
  input  wire logic [LEVEL_BITS-1:0]     q_prev,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [KIND_BITS-1:0]           out_kind,
  output logic [LEVEL_OUT_BITS-1:0]      out_level,
  output logic                           out_last,
  output logic [CNT_W-1:0]               stack_count
);

  back_state_t           state;
  back_state_t           state_next;
  logic [LEVEL_BITS-1:0] stack_mem [STACK_DEPTH];
  logic [LEVEL_BITS-1:0] top_q;
  logic [CNT_W-1:0]      cnt_m1;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;

  line_ctl_t             item_ctl;
  logic [LEVEL_BITS-1:0] item_cur;
  logic [LEVEL_BITS-1:0] item_prev;

  logic                  pend_valid;
  kind_t                 pend_kind;
  logic [LEVEL_BITS-1:0] pend_level;
  logic [LEVEL_OUT_BITS-1:0] pend_level_out;

  logic                  slot_free;
  logic                  stack_full;
  logic                  dedent_hit;
  logic                  load;
  logic                  produce;
  logic                  finish;
  logic                  push;
  logic                  pop;
  kind_t                 prod_kind;
  logic [LEVEL_BITS-1:0] prod_level;
  logic                  send;

  assign slot_free  = !out_valid || out_ready;
  assign stack_full = (stack_count == CNT_W'(STACK_DEPTH));
  assign cnt_m1     = stack_count - CNT_W'(1);
  assign rd_addr    = cnt_m1[IDX_W-1:0];
  assign wr_addr    = stack_count[IDX_W-1:0];
  assign dedent_hit = (stack_count != '0) &&
                      ((item_ctl.cmd == CMD_EOI) || (item_cur <= top_q));

  generate
    if (LEVEL_BITS >= LEVEL_OUT_BITS) begin : g_trunc
      assign pend_level_out = pend_level[LEVEL_OUT_BITS-1:0];
    end else begin : g_ext
      assign pend_level_out = {{(LEVEL_OUT_BITS - LEVEL_BITS){1'b0}}, pend_level};
    end
  endgenerate

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!q_empty) begin
          unique case (q_ctl.cmd)
            CMD_EOI:    state_next = S_WAIT;
            CMD_MIXED,
            CMD_INCONS: state_next = S_ERR;
            CMD_LINE: begin
              if (!q_ctl.colon) begin
                state_next = S_WAIT;
              end else if (q_ctl.malformed) begin
                state_next = S_MALF;
              end else begin
                state_next = S_PUSH;
              end
            end
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ERR:  if (slot_free) state_next = S_FIN;
      S_MALF: if (slot_free) state_next = S_PUSH;
      S_PUSH: if (slot_free) state_next = S_WAIT;
      S_WAIT: state_next = S_SCAN;
      S_SCAN: begin
        if (!dedent_hit) begin
          state_next = S_FIN;
        end else if (slot_free) begin
          state_next = S_WAIT;
        end
      end
      S_FIN:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop      = 1'b0;
    load       = 1'b0;
    produce    = 1'b0;
    finish     = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    prod_kind  = KIND_DEDENT;
    prod_level = top_q;
    unique case (state)
      S_IDLE: begin
        q_pop = !q_empty;
        load  = !q_empty;
      end
      S_ERR: begin
        produce    = slot_free;
        prod_kind  = (item_ctl.cmd == CMD_MIXED) ? KIND_MIXED : KIND_INCONSISTENT;
        prod_level = '0;
      end
      S_MALF: begin
        produce    = slot_free;
        prod_kind  = KIND_MALFORMED;
        prod_level = item_prev;
      end
      S_PUSH: begin
        produce    = slot_free;
        push       = slot_free && !stack_full;
        prod_kind  = stack_full ? KIND_OVERFLOW : KIND_INDENT;
        prod_level = item_cur;
      end
      S_WAIT: begin
      end
      S_SCAN: begin
        produce = slot_free && dedent_hit;
        pop     = slot_free && dedent_hit;
      end
      S_FIN: begin
        finish = slot_free;
      end
      default: begin
      end
    endcase
  end

  assign send = (produce || finish) && pend_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[wr_addr] <= item_prev;
    end
    top_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_ctl  <= q_ctl;
      item_cur  <= q_cur;
      item_prev <= q_prev;
    end
    if (produce) begin
      pend_kind  <= prod_kind;
      pend_level <= prod_level;
    end
    if (send) begin
      out_kind  <= pend_kind;
      out_level <= pend_level_out;
      out_last  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_count <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        stack_count <= stack_count + CNT_W'(1);
      end else if (pop) begin
        stack_count <= cnt_m1;
      end
      if (produce) begin
        pend_valid <= 1'b1;
      end else if (finish) begin
        pend_valid <= 1'b0;
      end
      if (send) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* design/offside_indent_tracker.sv */
// Offside indent tracker top level: front end, queue and stack engine.
// Depends on oit_pkg, oit_front, oit_fifo and oit_back.
//
// Usage: one transfer on the s_axis side per source line, carrying the space
// and tab counts of its leading whitespace and the colon / open-group flags;
// tlast marks the end-of-input item. Each line yields zero or more results on
// the m_axis side (indent, dedent, malformed, overflow, spacing report), tlast
// on the final result of that line. Lines inside a bracket group yield nothing.
// With the engine idle, a line's first result passes the queue and the item,
// pending-result and output registers. The engine takes an item in S_IDLE,
// gives each spacing/malformed/indent result its own state and each dedent
// S_WAIT and S_SCAN (the stack memory read is registered), and closes the line
// with the last stack read, scan and last-result hand-off, or with the hand-off
// alone after a spacing report. A 4-entry queue lets the front end keep taking
// lines while the engine works through a dedent run.
// Reset clears the queue, the stack count, the previous level and the spacing
// kind; stack memory contents are left as they are.
// When the receiver holds m_axis_tready low the engine stalls, the queue
// fills and s_axis_tready falls once it is full.
`default_nettype none

module offside_indent_tracker
  import oit_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int LEVEL_BITS  = DEF_LEVEL_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [IN_DATA_BITS-1:0]   s_axis_tdata,  // space_count, tab_count
  input  wire logic [IN_USER_BITS-1:0]   s_axis_tuser,  // after_colon, in_group
  input  wire logic                      s_axis_tlast,  // end_of_input
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic [LEVEL_OUT_BITS-1:0]      m_axis_tdata,  // level
  output logic [KIND_BITS-1:0]           m_axis_tuser,  // kind
  output logic                           m_axis_tlast   // last
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int Q_W    = $bits(line_ctl_t) + 2 * LEVEL_BITS;

  logic                  q_full;
  logic                  q_empty;
  logic                  q_push;
  logic                  q_pop;
  logic [FILL_W-1:0]     q_fill;
  logic [Q_W-1:0]        q_wr_data;
  logic [Q_W-1:0]        q_rd_data;
  line_ctl_t             f_ctl;
  logic [LEVEL_BITS-1:0] f_cur;
  logic [LEVEL_BITS-1:0] f_prev;
  line_ctl_t             b_ctl;
  logic [LEVEL_BITS-1:0] b_cur;
  logic [LEVEL_BITS-1:0] b_prev;
  logic [CNT_W-1:0]      stack_count;

  assign q_wr_data              = {f_ctl, f_cur, f_prev};
  assign {b_ctl, b_cur, b_prev} = q_rd_data;

  oit_front #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .space_count  (s_axis_tdata[7:0]),
    .tab_count    (s_axis_tdata[15:8]),
    .after_colon  (s_axis_tuser[0]),
    .in_group     (s_axis_tuser[1]),
    .end_of_input (s_axis_tlast),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_ctl        (f_ctl),
    .q_cur        (f_cur),
    .q_prev       (f_prev)
  );

  oit_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty),
    .fill    (q_fill)
  );

  oit_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_ctl       (b_ctl),
    .q_cur       (b_cur),
    .q_prev      (b_prev),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (m_axis_tuser),
    .out_level   (m_axis_tdata),
    .out_last    (m_axis_tlast),
    .stack_count (stack_count)
  );

`ifndef SYNTH
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_fill <= FILL_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_MIXED || m_axis_tuser == KIND_INCONSISTENT))
    |-> m_axis_tlast)
    else $error("spacing report not last result of its line");
`endif

endmodule

`default_nettype wire
